/* src/lcgu_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// lcgu_pkg
// Shared types, constants and rounding helpers for the uniform range draw.
// Values travel as signed fixed point in units of 2^-46.
// ----------------------------------------------------------------------------
package lcgu_pkg;

    localparam int unsigned FRAC_BITS = 46;
    localparam int unsigned VAL_W     = 82;
    localparam int unsigned MAG_W     = VAL_W - 1;
    localparam int unsigned KEEP_BITS = 53;

    localparam logic [31:0] SEED_ZERO_SUB = 32'd259341593;
    localparam logic [31:0] LCG_MUL       = 32'd69069;
    localparam logic signed [31:0] INT_MAX = 32'sh7fffffff;
    localparam logic signed [31:0] INT_MIN = 32'sh80000000;

    typedef logic signed [VAL_W-1:0] val_t;
    typedef logic [MAG_W-1:0] mag_t;

    localparam val_t VAL_ONE  = {35'd0, 1'b1, 46'd0};
    localparam val_t VAL_WRAP = {4'd0, 1'b1, 77'd0};

    typedef enum logic [1:0] {
        MODE_ORD,
        MODE_TOP,
        MODE_FULL
    } mode_t;

    typedef enum logic [1:0] {
        STEP_START,
        STEP_OFFSET,
        STEP_SHIFT,
        STEP_SIGN
    } step_t;

    typedef struct packed {
        logic               bypass;
        mode_t              mode;
        logic signed [31:0] rstart;
        logic signed [31:0] rend;
        logic signed [31:0] base;
        logic [31:0]        seed_res;
    } ctx_t;

    // round to 53 significant bits, nearest even
    function automatic mag_t round53(input mag_t m, input logic sticky);
        logic [6:0] t;
        logic [6:0] k;
        mag_t       mask;
        mag_t       half;
        mag_t       one_k;
        mag_t       low;
        logic       up;
        t = '0;
        for (int i = 0; i < MAG_W; i++)
        begin
            if (m[i])
            begin
                t = 7'(i);
            end
        end
        if (t < 7'(KEEP_BITS))
        begin
            return m;
        end
        k     = t - 7'(KEEP_BITS - 1);
        one_k = mag_t'(1) << k;
        mask  = one_k - mag_t'(1);
        half  = mag_t'(1) << (k - 7'd1);
        low   = m & mask;
        up    = (low > half) || ((low == half) && (sticky || ((m & one_k) != '0)));
        return (m & ~mask) + (up ? one_k : '0);
    endfunction

    function automatic val_t round_val(input val_t y, input logic sticky);
        logic neg;
        mag_t mag;
        mag_t r;
        val_t pos;
        neg = y[VAL_W-1];
        mag = neg ? mag_t'(-y) : y[MAG_W-1:0];
        r   = round53(mag, sticky);
        pos = $signed({1'b0, r});
        return neg ? -pos : pos;
    endfunction

    function automatic val_t addend(input step_t step, input ctx_t c, input val_t y);
        val_t r;
        r = '0;
        case (step)
            STEP_START:  r = $signed({{4{c.base[31]}}, c.base, 46'd0});
            STEP_OFFSET:
            begin
                if (c.mode == MODE_TOP)
                begin
                    r = VAL_ONE;
                end
                else if (c.mode == MODE_FULL)
                begin
                    r = VAL_WRAP;
                end
            end
            STEP_SHIFT:  r = (c.mode == MODE_FULL) ? -VAL_WRAP : '0;
            STEP_SIGN:   r = y[VAL_W-1] ? -VAL_ONE : '0;
            default:     r = '0;
        endcase
        return r;
    endfunction

endpackage
`default_nettype wire

/* src/lcgu_front.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// lcgu_front
// Seed advance, range setup, scaling product and first rounding (4 stages).
// ----------------------------------------------------------------------------
module lcgu_front
    import lcgu_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire logic        [31:0] seed_in,
    input  wire logic signed [31:0] range_start,
    input  wire logic signed [31:0] range_end,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output ctx_t                    out_ctx,
    output val_t                    out_val
);

    logic        v1_reg, v2_reg, v3_reg, v4_reg;
    logic        r1, r2, r3, r4;
    ctx_t        c1_reg, c2_reg, c3_reg, c4_reg;
    ctx_t        c1_next;
    logic [31:0] adv_reg, adv_next;
    logic [31:0] span_reg, span_next;
    logic [55:0] p1_reg;
    logic [54:0] p0_reg;
    logic [78:0] prod_reg;
    val_t        y_reg;
    logic [31:0] seed0;
    logic [22:0] frac;

    assign r4 = !v4_reg || out_ready;
    assign r3 = !v3_reg || r4;
    assign r2 = !v2_reg || r3;
    assign r1 = !v1_reg || r2;
    assign in_ready  = r1;
    assign out_valid = v4_reg;
    assign out_ctx   = c4_reg;
    assign out_val   = y_reg;

    always_comb
    begin
        seed0    = (seed_in == '0) ? SEED_ZERO_SUB : seed_in;
        adv_next = seed0 * LCG_MUL + 32'd1;
        c1_next.bypass = (range_start >= range_end);
        c1_next.rstart = range_start;
        c1_next.rend   = range_end;
        if (range_end != INT_MAX)
        begin
            c1_next.mode = MODE_ORD;
        end
        else if (range_start != INT_MIN)
        begin
            c1_next.mode = MODE_TOP;
        end
        else
        begin
            c1_next.mode = MODE_FULL;
        end
        c1_next.base = (c1_next.mode == MODE_TOP) ? range_start - 32'sd1 : range_start;
        span_next    = (c1_next.mode == MODE_FULL) ? 32'(range_end - range_start)
                                                   : 32'(range_end - range_start + 32'sd1);
        c1_next.seed_res = c1_next.bypass ? seed_in : adv_next;
    end

    assign frac = adv_reg[31:9];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            if (r1) v1_reg <= in_valid;
            if (r2) v2_reg <= v1_reg;
            if (r3) v3_reg <= v2_reg;
            if (r4) v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (r1)
        begin
            c1_reg   <= c1_next;
            adv_reg  <= adv_next;
            span_reg <= span_next;
        end
        if (r2)
        begin
            c2_reg <= c1_reg;
            p1_reg <= span_reg * {1'b0, frac} + {24'd0, span_reg};
            p0_reg <= span_reg * frac;
        end
        if (r3)
        begin
            c3_reg   <= c2_reg;
            prod_reg <= {p1_reg[55:0], 23'd0} + {24'd0, p0_reg};
        end
        if (r4)
        begin
            c4_reg <= c3_reg;
            y_reg  <= round_val($signed({3'd0, prod_reg}), 1'b0);
        end
    end

endmodule
`default_nettype wire

/* src/lcgu_addrnd.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// lcgu_addrnd
// Adds a step-dependent constant, then rounds to 53 bits (2 stages).
// ----------------------------------------------------------------------------
module lcgu_addrnd
    import lcgu_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire step_t step,
    input  wire logic  in_valid,
    output logic       in_ready,
    input  wire ctx_t  in_ctx,
    input  wire val_t  in_val,
    output logic       out_valid,
    input  wire logic  out_ready,
    output ctx_t       out_ctx,
    output val_t       out_val
);

    logic v1_reg, v2_reg;
    logic r1, r2;
    ctx_t c1_reg, c2_reg;
    val_t s_reg, y_reg;

    assign r2 = !v2_reg || out_ready;
    assign r1 = !v1_reg || r2;
    assign in_ready  = r1;
    assign out_valid = v2_reg;
    assign out_ctx   = c2_reg;
    assign out_val   = y_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else
        begin
            if (r1) v1_reg <= in_valid;
            if (r2) v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (r1)
        begin
            c1_reg <= in_ctx;
            s_reg  <= in_val + addend(step, in_ctx, in_val);
        end
        if (r2)
        begin
            c2_reg <= c1_reg;
            y_reg  <= round_val(s_reg, 1'b0);
        end
    end

endmodule
`default_nettype wire

/* src/lcgu_div.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// lcgu_div
// In full-range mode, divide by 2^32-1 with correct rounding; other modes pass through (3 stages).
// ----------------------------------------------------------------------------
module lcgu_div
    import lcgu_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic in_valid,
    output logic      in_ready,
    input  wire ctx_t in_ctx,
    input  wire val_t in_val,
    output logic      out_valid,
    input  wire logic out_ready,
    output ctx_t      out_ctx,
    output val_t      out_val
);

    localparam logic [34:0] DIV_D = 35'h0_ffff_ffff;

    logic        v1_reg, v2_reg, v3_reg;
    logic        r1, r2, r3;
    ctx_t        c1_reg, c2_reg, c3_reg;
    val_t        y1_reg, y3_reg;
    logic [47:0] est_reg, est_next;
    logic [34:0] t_reg, t_next;
    logic [79:0] q_reg;
    logic        sticky_reg;
    logic [1:0]  kq;
    logic [34:0] rem;
    logic [78:0] xv;

    assign r3 = !v3_reg || out_ready;
    assign r2 = !v2_reg || r3;
    assign r1 = !v1_reg || r2;
    assign in_ready  = r1;
    assign out_valid = v3_reg;
    assign out_ctx   = c3_reg;
    assign out_val   = y3_reg;

    // quotient estimate from 32-bit digits, low residue
    always_comb
    begin
        xv       = in_val[78:0];
        est_next = {1'b0, xv[78:64], 32'd0} + {16'd0, xv[63:32]} + {33'd0, xv[78:64]};
        t_next   = xv[34:0] - {est_next[2:0], 32'd0} + est_next[34:0];
    end

    always_comb
    begin
        if (t_reg >= 35'(3 * 64'(DIV_D)))
        begin
            kq = 2'd3;
        end
        else if (t_reg >= 35'(2 * 64'(DIV_D)))
        begin
            kq = 2'd2;
        end
        else if (t_reg >= DIV_D)
        begin
            kq = 2'd1;
        end
        else
        begin
            kq = 2'd0;
        end
        rem = t_reg - 35'(kq) * DIV_D;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            if (r1) v1_reg <= in_valid;
            if (r2) v2_reg <= v1_reg;
            if (r3) v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (r1)
        begin
            c1_reg  <= in_ctx;
            y1_reg  <= in_val;
            est_reg <= est_next;
            t_reg   <= t_next;
        end
        if (r2)
        begin
            c2_reg     <= c1_reg;
            q_reg      <= (c1_reg.mode == MODE_FULL)
                          ? {1'b0, y1_reg[78:0]} + {32'd0, est_reg} + {78'd0, kq}
                          : y1_reg[79:0];
            sticky_reg <= (c1_reg.mode == MODE_FULL) && (rem != '0);
        end
        if (r3)
        begin
            c3_reg <= c2_reg;
            y3_reg <= (c2_reg.mode == MODE_FULL)
                      ? round_val($signed({2'd0, q_reg}), sticky_reg)
                      : $signed({{2{q_reg[79]}}, q_reg});
        end
    end

endmodule
`default_nettype wire

/* src/lcg_uniform_int_range.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// lcg_uniform_int_range
// Uniform integer draw over a signed inclusive range from the 69069 LCG.
//
//   channel   dir   word fields (low bits first)
//   s_t*      in    seed_in, range_start, range_end
//   m_t*      out   draw_value, seed_out
//
// one word per cycle sustained while m_tready is high; each word runs to the output register
// through the chain of 53-bit rounding stages and the divider
// every stage holds its own valid bit; a stall fills bubbles before it stops
// the input, nothing is lost or repeated
// rst_n clears the valid bits only
// ----------------------------------------------------------------------------
module lcg_uniform_int_range
    import lcgu_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [95:0] s_tdata,   // seed_in, range_start, range_end
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [63:0]      m_tdata    // draw_value, seed_out
);

    logic vf, rf, va, ra, vo, ro, vd, rd, vs, rs, vn, rn;
    ctx_t cf, ca, co, cd, cs, cn;
    val_t yf, ya, yo, yd, ys, yn;

    logic               vo_reg;
    logic signed [31:0] draw_reg, draw_next;
    logic [31:0]        seed_reg;
    logic               neg;
    logic [34:0]        ip;
    logic signed [36:0] iv;

    lcgu_front u_front (
        .clk(clk), .rst_n(rst_n),
        .in_valid(s_tvalid), .in_ready(s_tready),
        .seed_in(s_tdata[31:0]),
        .range_start($signed(s_tdata[63:32])),
        .range_end($signed(s_tdata[95:64])),
        .out_valid(vf), .out_ready(rf), .out_ctx(cf), .out_val(yf)
    );

    lcgu_addrnd u_start (
        .clk(clk), .rst_n(rst_n), .step(STEP_START),
        .in_valid(vf), .in_ready(rf), .in_ctx(cf), .in_val(yf),
        .out_valid(va), .out_ready(ra), .out_ctx(ca), .out_val(ya)
    );

    lcgu_addrnd u_offset (
        .clk(clk), .rst_n(rst_n), .step(STEP_OFFSET),
        .in_valid(va), .in_ready(ra), .in_ctx(ca), .in_val(ya),
        .out_valid(vo), .out_ready(ro), .out_ctx(co), .out_val(yo)
    );

    lcgu_div u_div (
        .clk(clk), .rst_n(rst_n),
        .in_valid(vo), .in_ready(ro), .in_ctx(co), .in_val(yo),
        .out_valid(vd), .out_ready(rd), .out_ctx(cd), .out_val(yd)
    );

    lcgu_addrnd u_shift (
        .clk(clk), .rst_n(rst_n), .step(STEP_SHIFT),
        .in_valid(vd), .in_ready(rd), .in_ctx(cd), .in_val(yd),
        .out_valid(vs), .out_ready(rs), .out_ctx(cs), .out_val(ys)
    );

    lcgu_addrnd u_sign (
        .clk(clk), .rst_n(rst_n), .step(STEP_SIGN),
        .in_valid(vs), .in_ready(rs), .in_ctx(cs), .in_val(ys),
        .out_valid(vn), .out_ready(rn), .out_ctx(cn), .out_val(yn)
    );

    assign rn = !vo_reg || m_tready;

    // truncate toward zero and clamp into the range; bypass returns range_start
    always_comb
    begin
        neg = yn[VAL_W-1];
        ip  = neg ? 35'(mag_t'(-yn) >> FRAC_BITS) : 35'(yn[MAG_W-1:0] >> FRAC_BITS);
        iv  = neg ? -$signed({2'd0, ip}) : $signed({2'd0, ip});
        if (cn.bypass || iv < 37'(cn.rstart))
        begin
            draw_next = cn.rstart;
        end
        else if (iv > 37'(cn.rend))
        begin
            draw_next = cn.rend;
        end
        else
        begin
            draw_next = iv[31:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vo_reg <= 1'b0;
        end
        else if (rn)
        begin
            vo_reg <= vn;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rn)
        begin
            draw_reg <= draw_next;
            seed_reg <= cn.seed_res;
        end
    end

    assign m_tvalid = vo_reg;
    assign m_tdata  = {seed_reg, draw_reg};

endmodule
`default_nettype wire
